[sv/pu_pkg.sv]
`default_nettype none
package pu_pkg;

    localparam int RANK_W  = 22;
    localparam int DIGIT_W = 4;
    localparam int PERM_W  = 40;
    localparam int DEC_W   = 34;
    localparam int FACT_W  = 64;

    typedef struct packed {
        logic valid;
        logic err;
    } t_ctrl;

    function automatic logic [FACT_W-1:0] fact(input int n);
        logic [FACT_W-1:0] f;
        f = FACT_W'(1);
        for (int k = 2; k <= n; k++) begin
            f = f * FACT_W'(k);
        end
        return f;
    endfunction

endpackage
`default_nettype wire

[sv/pu_stage.sv]
`default_nettype none
module pu_stage #(
    parameter int NUM_DIGITS = 10,
    parameter int POS        = 0
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire pu_pkg::t_ctrl                             i_ctrl,
    input  wire logic [pu_pkg::RANK_W-1:0]                 i_rem,
    input  wire logic [NUM_DIGITS*pu_pkg::DIGIT_W-1:0]     i_list,
    input  wire logic [pu_pkg::PERM_W-1:0]                 i_perm,
    input  wire logic [pu_pkg::DEC_W-1:0]                  i_dec,
    output pu_pkg::t_ctrl                                  o_ctrl,
    output logic [pu_pkg::RANK_W-1:0]                      o_rem,
    output logic [NUM_DIGITS*pu_pkg::DIGIT_W-1:0]          o_list,
    output logic [pu_pkg::PERM_W-1:0]                      o_perm,
    output logic [pu_pkg::DEC_W-1:0]                       o_dec
);
    import pu_pkg::*;

    localparam int K = NUM_DIGITS - 1 - POS;
    localparam logic [FACT_W-1:0] F = fact(K);

    logic [DIGIT_W-1:0] pick;
    logic [RANK_W-1:0]  sub;
    logic [DIGIT_W-1:0] digit;
    logic [NUM_DIGITS*DIGIT_W-1:0] list_nx;

    pu_pkg::t_ctrl                 r_ctrl, n_ctrl;
    logic [RANK_W-1:0]             r_rem, n_rem;
    logic [NUM_DIGITS*DIGIT_W-1:0] r_list;
    logic [PERM_W-1:0]             r_perm, n_perm;
    logic [DEC_W-1:0]              r_dec, n_dec;

    // quotient of the remaining zero-based rank by F, via parallel compares
    always_comb begin
        pick = '0;
        sub  = '0;
        for (int k = 1; k <= K; k++) begin
            if ({{(FACT_W-RANK_W){1'b0}}, i_rem} >= FACT_W'(k) * F) begin
                pick = DIGIT_W'(k);
                sub  = RANK_W'(FACT_W'(k) * F);
            end
        end
    end

    // take the pick-th unused digit and close the gap
    always_comb begin
        digit   = '0;
        list_nx = i_list;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (pick == DIGIT_W'(i)) begin
                digit = i_list[i*DIGIT_W +: DIGIT_W];
            end
        end
        for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            if (DIGIT_W'(i) >= pick) begin
                list_nx[i*DIGIT_W +: DIGIT_W] = i_list[(i+1)*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_ctrl = i_ctrl;
        n_rem  = i_rem - sub;
        n_perm = {i_perm[PERM_W-DIGIT_W-1:0], digit};
        n_dec  = (i_dec << 3) + (i_dec << 1) + {{(DEC_W-DIGIT_W){1'b0}}, digit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_list <= list_nx;
        r_perm <= n_perm;
        r_dec  <= n_dec;
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_list = r_list;
    assign o_perm = r_perm;
    assign o_dec  = r_dec;

endmodule
`default_nettype wire

[sv/permutation_unrank_top.sv]
// Lexicographic permutation unranker. Give a one-based rank on i_rank with start;
// start is taken on any cycle where busy is low; busy is a register that is set
// in reset and cleared once reset is released, so one rank per cycle is accepted.
// Each rank is worked through a pipeline of one register stage per digit
// position (NUM_DIGITS of them) plus an input and an output register, so its
// result appears with o_done after passing all of them, in start order. o_done
// is a single-cycle strobe and the result must be captured then; there is no
// way to hold it. A rank of zero or above NUM_DIGITS factorial sets
// o_rank_error and returns zero digits and a zero decimal value.
`default_nettype none
module permutation_unrank_top #(
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [pu_pkg::RANK_W-1:0]   i_rank,
    output logic                             o_done,
    output logic [pu_pkg::PERM_W-1:0]        o_perm_digits,
    output logic [pu_pkg::DEC_W-1:0]         o_decimal_value,
    output logic                             o_rank_error
);
    import pu_pkg::*;

    localparam int LIST_W = NUM_DIGITS * DIGIT_W;
    localparam logic [FACT_W-1:0] FACT_N = fact(NUM_DIGITS);

    logic r_busy;

    pu_pkg::t_ctrl     c_ctrl [0:NUM_DIGITS];
    logic [RANK_W-1:0] c_rem  [0:NUM_DIGITS];
    logic [LIST_W-1:0] c_list [0:NUM_DIGITS];
    logic [PERM_W-1:0] c_perm [0:NUM_DIGITS];
    logic [DEC_W-1:0]  c_dec  [0:NUM_DIGITS];

    pu_pkg::t_ctrl     r_in_ctrl, n_in_ctrl;
    logic [RANK_W-1:0] r_in_rem;
    logic [LIST_W-1:0] init_list;

    logic              r_done;
    logic [PERM_W-1:0] r_perm;
    logic [DEC_W-1:0]  r_dec;
    logic              r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    // input register: range check and switch to a zero-based rank
    always_comb begin
        n_in_ctrl.valid = start && !r_busy;
        n_in_ctrl.err   = (i_rank == '0) ||
                          ({{(FACT_W-RANK_W){1'b0}}, i_rank} > FACT_N);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctrl <= '0;
        end else begin
            r_in_ctrl <= n_in_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_rem <= i_rank - RANK_W'(1);
    end

    always_comb begin
        init_list = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            init_list[i*DIGIT_W +: DIGIT_W] = DIGIT_W'(i);
        end
    end

    assign c_ctrl[0] = r_in_ctrl;
    assign c_rem[0]  = r_in_rem;
    assign c_list[0] = init_list;
    assign c_perm[0] = '0;
    assign c_dec[0]  = '0;

    for (genvar p = 0; p < NUM_DIGITS; p++) begin : g_pos
        pu_stage #(
            .NUM_DIGITS (NUM_DIGITS),
            .POS        (p)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (c_ctrl[p]),
            .i_rem   (c_rem[p]),
            .i_list  (c_list[p]),
            .i_perm  (c_perm[p]),
            .i_dec   (c_dec[p]),
            .o_ctrl  (c_ctrl[p+1]),
            .o_rem   (c_rem[p+1]),
            .o_list  (c_list[p+1]),
            .o_perm  (c_perm[p+1]),
            .o_dec   (c_dec[p+1])
        );
    end

    // output register, results forced to zero on a bad rank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c_ctrl[NUM_DIGITS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err  <= c_ctrl[NUM_DIGITS].err;
        r_perm <= c_ctrl[NUM_DIGITS].err ? '0 : c_perm[NUM_DIGITS];
        r_dec  <= c_ctrl[NUM_DIGITS].err ? '0 : c_dec[NUM_DIGITS];
    end

    assign o_done          = r_done;
    assign o_perm_digits   = r_perm;
    assign o_decimal_value = r_dec;
    assign o_rank_error    = r_err;

endmodule
`default_nettype wire

[sv/pu_checker.sv]
`default_nettype none
module pu_checker #(
    parameter int NUM_DIGITS = 10
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic [pu_pkg::RANK_W-1:0]   i_rank,
    input wire logic                        o_done,
    input wire logic [pu_pkg::PERM_W-1:0]   o_perm_digits,
    input wire logic [pu_pkg::DEC_W-1:0]    o_decimal_value,
    input wire logic                        o_rank_error
);
    localparam int LAT = NUM_DIGITS + 2;

    // every accepted item comes out after the fixed latency
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_done)
        else $error("accepted item did not complete on time");

    // no result without an item accepted at the matching time
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without an accepted item");

    // zero rank always flags an error
    a_zero_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_rank == '0 |-> ##LAT (o_done && o_rank_error))
        else $error("zero rank not flagged");

    // error results carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rank_error |-> o_perm_digits == '0 && o_decimal_value == '0)
        else $error("error result with nonzero payload");

endmodule

bind permutation_unrank_top pu_checker #(
    .NUM_DIGITS (NUM_DIGITS)
) u_pu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_rank          (i_rank),
    .o_done          (o_done),
    .o_perm_digits   (o_perm_digits),
    .o_decimal_value (o_decimal_value),
    .o_rank_error    (o_rank_error)
);
`default_nettype wire
